// ----- src/format_string_integer_printer_core_macros.svh -----
// Assertion macros used by the checker file of the format printer.
`ifndef FORMAT_STRING_INTEGER_PRINTER_CORE_MACROS_SVH
`define FORMAT_STRING_INTEGER_PRINTER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define FSIP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("format printer check failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define FSIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("format printer check failed");

`endif

// ----- src/fsip_pkg.sv -----
// Shared types, constants and helper functions of the format printer.
package fsip_pkg;

    // Sizing of the argument path, the digit stack and the command queue.
    localparam int ARG_WIDTH   = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

    // Reciprocal of ten scaled by 2^(ARG_WIDTH+3), rounded up.
    localparam int DEC_SHIFT = ARG_WIDTH + 3;
    localparam logic [ARG_WIDTH+3:0] DEC_SCALE = {1'b1, {(ARG_WIDTH + 3){1'b0}}};
    localparam logic [ARG_WIDTH+3:0] DEC_RECIP_WIDE = DEC_SCALE / 10 + 1;
    localparam logic [ARG_WIDTH-1:0] DEC_RECIP = DEC_RECIP_WIDE[ARG_WIDTH-1:0];

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Request kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_ARG  = 1'b1;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_PCT   = 3'd1,
        MODE_DEC   = 3'd2,
        MODE_HEX   = 3'd3,
        MODE_CHR   = 3'd4
    } mode_t;

    // Commands passed from the parser to the printer.
    typedef enum logic [2:0] {
        OP_ECHO,
        OP_PCT_ECHO,
        OP_ERROR,
        OP_DEC,
        OP_HEX
    } op_t;

    // Printer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_CONV,
        B_EMIT,
        B_PCT,
        B_ONE
    } back_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_char;
        logic [31:0] arg_value;
    } req_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       error;
    } res_t;

    typedef struct packed {
        op_t                  op;
        logic [7:0]           ch;
        logic [ARG_WIDTH-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // ASCII character of one decimal or hex digit.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] wide;
        wide = {4'h0, d};
        return (d > 4'd9) ? (wide + CH_SEVEN) : (wide + CH_ZERO);
    endfunction

endpackage

// ----- src/fsip_front.sv -----
// Parser: accepts requests, tracks the format mode and issues print commands.
module fsip_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  fsip_pkg::req_t       req,
    input  fsip_pkg::q_status_t  qs,
    output logic                 push,
    output fsip_pkg::cmd_t       cmd
);

    fsip_pkg::mode_t mode_reg;
    fsip_pkg::mode_t mode_next;
    fsip_pkg::mode_t cur_mode;
    fsip_pkg::mode_t cls_mode;
    logic            cls_push;
    logic            want_arg;
    logic            is_arg;
    logic            accept;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fsip_pkg::MODE_PLAIN;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Classify the request against the current mode.
    always_comb
    begin
        if (mode_reg inside {fsip_pkg::MODE_PCT, fsip_pkg::MODE_DEC,
                             fsip_pkg::MODE_HEX, fsip_pkg::MODE_CHR})
        begin
            cur_mode = mode_reg;
        end
        else
        begin
            cur_mode = fsip_pkg::MODE_PLAIN;
        end
        want_arg = cur_mode inside {fsip_pkg::MODE_DEC, fsip_pkg::MODE_HEX,
                                    fsip_pkg::MODE_CHR};
        is_arg   = (req.kind == fsip_pkg::KIND_ARG);

        cls_push  = 1'b0;
        cls_mode  = cur_mode;
        cmd.op    = fsip_pkg::OP_ECHO;
        cmd.ch    = req.text_char;
        cmd.value = fsip_pkg::ARG_WIDTH'(req.arg_value);

        if (is_arg != want_arg)
        begin
            // Wrong kind of request: one error result, mode kept as it was.
            cls_push = 1'b1;
            cmd.op   = fsip_pkg::OP_ERROR;
            cmd.ch   = fsip_pkg::CH_NUL;
            cls_mode = mode_reg;
        end
        else
        begin
            case (cur_mode)
                fsip_pkg::MODE_PCT:
                begin
                    if (req.text_char == fsip_pkg::CH_D)
                    begin
                        cls_mode = fsip_pkg::MODE_DEC;
                    end
                    else if (req.text_char == fsip_pkg::CH_X)
                    begin
                        cls_mode = fsip_pkg::MODE_HEX;
                    end
                    else if (req.text_char == fsip_pkg::CH_C)
                    begin
                        cls_mode = fsip_pkg::MODE_CHR;
                    end
                    else
                    begin
                        cls_push = 1'b1;
                        cls_mode = fsip_pkg::MODE_PLAIN;
                        if (req.text_char == fsip_pkg::CH_NUL)
                        begin
                            // A percent sign left open at the end prints alone.
                            cmd.ch = fsip_pkg::CH_PCT;
                        end
                        else
                        begin
                            cmd.op = fsip_pkg::OP_PCT_ECHO;
                        end
                    end
                end
                fsip_pkg::MODE_DEC:
                begin
                    cls_push = 1'b1;
                    cmd.op   = fsip_pkg::OP_DEC;
                    cls_mode = fsip_pkg::MODE_PLAIN;
                end
                fsip_pkg::MODE_HEX:
                begin
                    cls_push = 1'b1;
                    cmd.op   = fsip_pkg::OP_HEX;
                    cls_mode = fsip_pkg::MODE_PLAIN;
                end
                fsip_pkg::MODE_CHR:
                begin
                    cls_push = 1'b1;
                    cmd.ch   = req.arg_value[7:0];
                    cls_mode = fsip_pkg::MODE_PLAIN;
                end
                default:
                begin
                    if (req.text_char == fsip_pkg::CH_PCT)
                    begin
                        cls_mode = fsip_pkg::MODE_PCT;
                    end
                    else
                    begin
                        cls_mode = fsip_pkg::MODE_PLAIN;
                        cls_push = (req.text_char != fsip_pkg::CH_NUL);
                    end
                end
            endcase
        end

        // Take the request only when the queue has room.
        req_stall = qs.full;
        accept    = req_valid && !qs.full;
        push      = accept && cls_push;
        mode_next = accept ? cls_mode : mode_reg;
    end

endmodule

// ----- src/fsip_queue.sv -----
// Short command queue between the parser and the printer.
module fsip_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fsip_pkg::cmd_t       wr,
    input  logic                 pop,
    output fsip_pkg::cmd_t       rd,
    output fsip_pkg::q_status_t  qs
);

    localparam int PTR_W = $clog2(fsip_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fsip_pkg::QUEUE_DEPTH + 1);

    fsip_pkg::cmd_t   entries_reg [fsip_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    // Pointer and fill count update.
    always_comb
    begin
        qs.full  = (count_reg == CNT_W'(fsip_pkg::QUEUE_DEPTH));
        qs.empty = (count_reg == '0);
        do_push  = push && !qs.full;
        do_pop   = pop && !qs.empty;
        rd       = entries_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fsip_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fsip_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr;
        end
    end

endmodule

// ----- src/fsip_back.sv -----
// Printer: carries out commands, converts numbers to digits and drives results.
module fsip_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsip_pkg::q_status_t  qs,
    input  fsip_pkg::cmd_t       rd,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output fsip_pkg::res_t       res
);

    localparam int W  = fsip_pkg::ARG_WIDTH;
    localparam int CW = fsip_pkg::DIGIT_CNT_W;

    fsip_pkg::back_state_t state_reg;
    fsip_pkg::back_state_t state_next;
    logic [W-1:0]          val_reg;
    logic [W-1:0]          val_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  hex_reg;
    logic                  hex_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [3:0]            digits_reg [fsip_pkg::MAX_DIGITS];
    logic [3:0]            digits_next [fsip_pkg::MAX_DIGITS];
    logic [7:0]            ch_reg;
    logic [7:0]            ch_next;
    logic                  err_reg;
    logic                  err_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    fsip_pkg::res_t        res_reg;
    fsip_pkg::res_t        res_next;

    logic                  can_load;
    logic                  load;
    fsip_pkg::res_t        load_data;
    logic [2*W-1:0]        prod;
    logic [W-1:0]          quot;
    logic [W-1:0]          quot_x10;
    logic [W-1:0]          rem_wide;
    logic [3:0]            rem;

    // One digit step: divide by ten through the reciprocal, or by sixteen.
    always_comb
    begin
        prod     = val_reg * fsip_pkg::DEC_RECIP;
        quot_x10 = '0;
        rem_wide = '0;
        if (hex_reg)
        begin
            quot = val_reg >> 4;
            rem  = val_reg[3:0];
        end
        else
        begin
            quot     = W'(prod >> fsip_pkg::DEC_SHIFT);
            quot_x10 = (quot << 3) + (quot << 1);
            rem_wide = val_reg - quot_x10;
            rem      = rem_wide[3:0];
        end
    end

    // Sequencer and output register control.
    always_comb
    begin
        can_load    = !res_valid_reg || !res_stall;
        state_next  = state_reg;
        val_next    = val_reg;
        neg_next    = neg_reg;
        hex_next    = hex_reg;
        cnt_next    = cnt_reg;
        digits_next = digits_reg;
        ch_next     = ch_reg;
        err_next    = err_reg;
        pop         = 1'b0;
        load        = 1'b0;
        load_data   = '{out_char: fsip_pkg::CH_NUL, last: 1'b0, error: 1'b0};

        case (state_reg)
            fsip_pkg::B_IDLE:
            begin
                if (!qs.empty)
                begin
                    pop = 1'b1;
                    case (rd.op)
                        fsip_pkg::OP_ECHO:
                        begin
                            ch_next    = rd.ch;
                            err_next   = 1'b0;
                            state_next = fsip_pkg::B_ONE;
                        end
                        fsip_pkg::OP_PCT_ECHO:
                        begin
                            ch_next    = rd.ch;
                            err_next   = 1'b0;
                            state_next = fsip_pkg::B_PCT;
                        end
                        fsip_pkg::OP_ERROR:
                        begin
                            ch_next    = fsip_pkg::CH_NUL;
                            err_next   = 1'b1;
                            state_next = fsip_pkg::B_ONE;
                        end
                        fsip_pkg::OP_DEC:
                        begin
                            // Magnitude of the two's complement word.
                            neg_next   = rd.value[W-1];
                            val_next   = rd.value[W-1] ? (~rd.value + W'(1)) : rd.value;
                            hex_next   = 1'b0;
                            cnt_next   = '0;
                            state_next = fsip_pkg::B_CONV;
                        end
                        fsip_pkg::OP_HEX:
                        begin
                            neg_next   = 1'b0;
                            val_next   = rd.value;
                            hex_next   = 1'b1;
                            cnt_next   = '0;
                            state_next = fsip_pkg::B_CONV;
                        end
                        default:
                        begin
                            state_next = fsip_pkg::B_IDLE;
                        end
                    endcase
                end
            end
            fsip_pkg::B_CONV:
            begin
                // Push the low digit onto the stack; the sign may leave meanwhile.
                digits_next[0] = rem;
                for (int i = 1; i < fsip_pkg::MAX_DIGITS; i++)
                begin
                    digits_next[i] = digits_reg[i-1];
                end
                val_next = quot;
                cnt_next = cnt_reg + CW'(1);
                if ((quot == '0) || (cnt_reg == CW'(fsip_pkg::MAX_DIGITS - 1)))
                begin
                    state_next = fsip_pkg::B_EMIT;
                end
                if (neg_reg && can_load)
                begin
                    load      = 1'b1;
                    load_data = '{out_char: fsip_pkg::CH_MINUS, last: 1'b0, error: 1'b0};
                    neg_next  = 1'b0;
                end
            end
            fsip_pkg::B_EMIT:
            begin
                if (can_load)
                begin
                    load = 1'b1;
                    if (neg_reg)
                    begin
                        load_data = '{out_char: fsip_pkg::CH_MINUS, last: 1'b0,
                                      error: 1'b0};
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        // Pop the most significant digit still held.
                        load_data = '{out_char: fsip_pkg::digit_char(digits_reg[0]),
                                      last: (cnt_reg == CW'(1)), error: 1'b0};
                        for (int i = 0; i < fsip_pkg::MAX_DIGITS - 1; i++)
                        begin
                            digits_next[i] = digits_reg[i+1];
                        end
                        digits_next[fsip_pkg::MAX_DIGITS-1] = 4'h0;
                        cnt_next = cnt_reg - CW'(1);
                        if (cnt_reg == CW'(1))
                        begin
                            state_next = fsip_pkg::B_IDLE;
                        end
                    end
                end
            end
            fsip_pkg::B_PCT:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    load_data  = '{out_char: fsip_pkg::CH_PCT, last: 1'b0, error: 1'b0};
                    state_next = fsip_pkg::B_ONE;
                end
            end
            fsip_pkg::B_ONE:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    load_data  = '{out_char: ch_reg, last: 1'b1, error: err_reg};
                    state_next = fsip_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = fsip_pkg::B_IDLE;
            end
        endcase

        // Output register: load a new result or drain the taken one.
        res_next = res_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
            res_next       = load_data;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsip_pkg::B_IDLE;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        hex_reg    <= hex_next;
        digits_reg <= digits_next;
        ch_reg     <= ch_next;
        err_reg    <= err_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- src/format_string_integer_printer_core.sv -----
// Top level of the format printer: parser, command queue and printer.
//
// The block takes format text characters and argument words on the request
// channel and returns one printed character per result, with last marking the
// final character caused by a request. A parser accepts a request every cycle
// while its two-entry command queue has room; the printer works through one
// command at a time. In the printer a plain or single character is fetched
// from the queue and then loaded into the output register, and an unknown
// specifier first loads a percent sign. A %d or %x argument runs through the
// digit loop, one digit per cycle (a multiply by the reciprocal of ten for
// decimal, a four-bit shift for hex), then emits one character per cycle while
// the output register can load, the minus sign leaving in the loop if it can:
// a 32-bit decimal argument has up to 10 digits, a hex one up to 8. The result
// channel has a single output register, so a stall on it keeps the printer
// from loading (its digit loop runs on) and the parser only once the queue fills.
module format_string_integer_printer_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  fsip_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_stall,
    output fsip_pkg::res_t  res
);

    fsip_pkg::q_status_t qs;
    fsip_pkg::cmd_t      wr_cmd;
    fsip_pkg::cmd_t      rd_cmd;
    logic                push;
    logic                pop;

    // Request parser.
    fsip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .qs        (qs),
        .push      (push),
        .cmd       (wr_cmd)
    );

    // Command queue.
    fsip_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wr    (wr_cmd),
        .pop   (pop),
        .rd    (rd_cmd),
        .qs    (qs)
    );

    // Character printer.
    fsip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qs        (qs),
        .rd        (rd_cmd),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ----- src/fsip_checker.sv -----
// Port-level checks on the format printer, bound to the top level.
`include "format_string_integer_printer_core_macros.svh"

module fsip_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            res_valid,
    input logic            res_stall,
    input fsip_pkg::res_t  res
);

    // A stalled result stays put.
    `FSIP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

    // An error result is a lone zero character.
    `FSIP_ASSERT_IMPLY(a_err_form, res_valid && res.error, (res.out_char == 8'h00) && res.last)

    // Only the final character of a request can be zero: signs, digits and
    // echoed text are never zero.
    `FSIP_ASSERT_IMPLY(a_mid_nonzero, res_valid && !res.last, res.out_char != 8'h00)

    // Nothing comes out in the first cycle after reset.
    `FSIP_ASSERT_IMPLY(a_reset_quiet, $rose(rst_n), !res_valid)

endmodule

bind format_string_integer_printer_core fsip_checker u_fsip_checker (.*);
